>>> rtl/bhd_pkg.sv
`timescale 1ns / 1ps

package bhd_pkg;

   // frame geometry limits
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int ADDR_W     = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);

   // field widths
   localparam int SIZE_W  = 11;
   localparam int PIX_W   = 8;
   localparam int COUNT_W = 20;
   localparam int CSR_W   = 11;
   localparam int IDX_W   = 2;

   localparam logic [SIZE_W-1:0]  SIZE_MIN   = SIZE_W'(2);
   localparam logic [SIZE_W-1:0]  WIDTH_MAX  = SIZE_W'(MAX_WIDTH);
   localparam logic [SIZE_W-1:0]  HEIGHT_MAX = SIZE_W'(MAX_HEIGHT);
   localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};
   localparam logic [PIX_W-1:0]   PIX_ON     = 8'd255;
   localparam logic [PIX_W-1:0]   PIX_OFF    = 8'd0;

   // register reset values
   localparam logic [SIZE_W-1:0] WIDTH_RST  = 11'd256;
   localparam logic [SIZE_W-1:0] HEIGHT_RST = 11'd256;
   localparam logic [PIX_W-1:0]  THRESH_RST = 8'd128;

   // register indexes
   localparam logic [IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [IDX_W-1:0] CSR_THRESHOLD    = 2'd2;

   // result slots of one input pixel, in emission order
   localparam logic [1:0] SLOT_CUR_ROW      = 2'd0;
   localparam logic [1:0] SLOT_LAST_ROW     = 2'd1;
   localparam logic [1:0] SLOT_EDGE_COL     = 2'd2;
   localparam logic [1:0] SLOT_FRAME_CORNER = 2'd3;

   // window: column k (0 oldest..2 newest), slot s (0 older, 1 newer, 2 current)
   typedef logic [8:0] win_type;

   typedef struct packed {
      logic newer;
      logic older;
   } ls_entry_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } ls_rd_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      ls_entry_type      data;
   } ls_wr_type;

   function automatic logic wbit(win_type win, logic [1:0] k, logic [1:0] s);
      logic [3:0] idx;
      idx = {2'b00, k} * 4'd3 + {2'b00, s};
      return win[idx];
   endfunction

   // returns {hit, centre} for a pinhole: ring of ones around a zero
   function automatic logic [1:0] hole_eval(win_type win,
                                            logic [1:0] kl, logic [1:0] kc,
                                            logic [1:0] kr, logic [1:0] st,
                                            logic [1:0] sm, logic [1:0] sb);
      logic ring;
      logic centre;
      ring = wbit(win, kl, st) & wbit(win, kc, st) & wbit(win, kr, st)
           & wbit(win, kl, sm) & wbit(win, kr, sm)
           & wbit(win, kl, sb) & wbit(win, kc, sb) & wbit(win, kr, sb);
      centre = wbit(win, kc, sm);
      return {ring & ~centre, centre};
   endfunction

endpackage

>>> rtl/bhd_req_if.sv
`timescale 1ns / 1ps

interface bhd_req_if;
   logic                      valid;
   logic                      ready;
   logic [bhd_pkg::PIX_W-1:0] grey_pixel;

   modport source (output valid, output grey_pixel, input ready);
   modport sink   (input valid, input grey_pixel, output ready);
endinterface

>>> rtl/bhd_rsp_if.sv
`timescale 1ns / 1ps

interface bhd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [bhd_pkg::PIX_W-1:0]   out_pixel;
   logic                        is_defect;
   logic [bhd_pkg::SIZE_W-1:0]  pixel_col;
   logic [bhd_pkg::SIZE_W-1:0]  pixel_row;
   logic [bhd_pkg::COUNT_W-1:0] defect_total;
   logic                        run_last;
   logic                        frame_done;

   modport source (output valid, output out_pixel, output is_defect, output pixel_col,
                   output pixel_row, output defect_total, output run_last,
                   output frame_done, input ready);
   modport sink   (input valid, input out_pixel, input is_defect, input pixel_col,
                   input pixel_row, input defect_total, input run_last,
                   input frame_done, output ready);
endinterface

>>> rtl/binary_hole_defect_detector.sv
`timescale 1ns / 1ps

// Channel  Dir  Beat content
// req      in   grey_pixel, raster order
// rsp      out  out_pixel, is_defect, pixel_col, pixel_row, defect_total,
//               run_last, frame_done
// csr      in   csr_wr_en, csr_index, csr_wdata (write only)
//
// A pixel beat is taken every cycle when rsp is not stalled and each pixel yields
// at most one result beat; a pixel yielding more holds the work stage until its last
// beat is emitted. Row 0 and column 0 pixels yield none, inner pixels one, the last
// column of a row two; the last row doubles each, so four on the last pixel of the
// frame. The rsp output register passes one result beat per cycle while rsp is ready,
// which bounds the rate. Reset clears counters, window and pipeline valids and loads
// the register reset values; the line store needs no clearing. A stalled rsp beat holds;
// req keeps flowing into the work stage until it also fills.
module binary_hole_defect_detector (
   input  logic                          clock,
   input  logic                          reset,
   bhd_req_if.sink                       req,
   bhd_rsp_if.source                     rsp,
   input  logic                          csr_wr_en,
   input  logic [bhd_pkg::IDX_W-1:0]     csr_index,
   input  logic [bhd_pkg::CSR_W-1:0]     csr_wdata
);

   localparam int AW = bhd_pkg::ADDR_W;
   localparam int RW = bhd_pkg::ROW_W;
   localparam int SW = bhd_pkg::SIZE_W;
   localparam int CW = bhd_pkg::COUNT_W;

   typedef struct packed {
      logic [bhd_pkg::PIX_W-1:0] out_pixel;
      logic                      is_defect;
      logic [SW-1:0]             pixel_col;
      logic [SW-1:0]             pixel_row;
      logic [CW-1:0]             defect_total;
      logic                      run_last;
      logic                      frame_done;
   } beat_type;

   // ---------------- configuration ----------------
   logic [SW-1:0]              width_ff, width_in;
   logic [SW-1:0]              height_ff, height_in;
   logic [bhd_pkg::PIX_W-1:0]  thresh_ff, thresh_in;
   logic                       size_wr;

   assign size_wr = csr_wr_en && (csr_index == bhd_pkg::CSR_FRAME_WIDTH ||
                                  csr_index == bhd_pkg::CSR_FRAME_HEIGHT);

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      thresh_in = thresh_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            bhd_pkg::CSR_FRAME_WIDTH:  width_in  = csr_wdata;
            bhd_pkg::CSR_FRAME_HEIGHT: height_in = csr_wdata;
            bhd_pkg::CSR_THRESHOLD:    thresh_in = csr_wdata[bhd_pkg::PIX_W-1:0];
            default:                   ;  // unknown index ignored
         endcase
      end
   end

   // clamp sizes into 2..max
   logic [SW-1:0] w_eff, h_eff, w_last, h_last;

   always_comb begin
      priority if (width_ff < bhd_pkg::SIZE_MIN)  w_eff = bhd_pkg::SIZE_MIN;
      else if (width_ff > bhd_pkg::WIDTH_MAX)     w_eff = bhd_pkg::WIDTH_MAX;
      else                                        w_eff = width_ff;
      priority if (height_ff < bhd_pkg::SIZE_MIN) h_eff = bhd_pkg::SIZE_MIN;
      else if (height_ff > bhd_pkg::HEIGHT_MAX)   h_eff = bhd_pkg::HEIGHT_MAX;
      else                                        h_eff = height_ff;
   end

   assign w_last = w_eff - SW'(1);
   assign h_last = h_eff - SW'(1);

   // ---------------- input side: raster counters ----------------
   logic [AW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic          accept;
   logic          retire;
   logic          col_end, row_end;

   assign accept  = req.valid && req.ready;
   assign col_end = ({{(SW-AW){1'b0}}, col_ff} == w_last);
   assign row_end = ({{(SW-RW){1'b0}}, row_ff} == h_last);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (size_wr) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_end) begin
            col_in = '0;
            row_in = row_end ? '0 : row_ff + RW'(1);
         end else begin
            col_in = col_ff + AW'(1);
         end
      end
   end

   // which result slots this pixel produces
   logic [3:0] pend_new;
   logic       has_rows;
   logic       has_left;

   assign has_rows = (row_ff != '0);
   assign has_left = (col_ff != '0);

   always_comb begin
      pend_new[bhd_pkg::SLOT_CUR_ROW]      = has_rows && has_left;
      pend_new[bhd_pkg::SLOT_LAST_ROW]     = has_rows && has_left && row_end;
      pend_new[bhd_pkg::SLOT_EDGE_COL]     = has_rows && col_end;
      pend_new[bhd_pkg::SLOT_FRAME_CORNER] = has_rows && col_end && row_end;
   end

   // ---------------- line store ----------------
   bhd_pkg::ls_rd_type    ls_rd;
   bhd_pkg::ls_wr_type    ls_wr;
   bhd_pkg::ls_entry_type ls_q;

   assign ls_rd.en   = accept;
   assign ls_rd.addr = col_ff;

   bhd_line_store u_line_store (
      .clock   (clock),
      .rd      (ls_rd),
      .rd_data (ls_q),
      .wr      (ls_wr)
   );

   // ---------------- work stage ----------------
   logic          s1_valid_ff, s1_valid_in;
   logic [AW-1:0] s1_col_ff;
   logic [RW-1:0] s1_row_ff;
   logic          s1_cur_ff;
   logic          s1_left_ff;   // column 1: left neighbor mirrors to column 1
   logic          s1_top_ff;    // row 1: top neighbor mirrors to row 1
   logic          s1_wrap_ff;   // last pixel of the frame
   logic [3:0]    s1_pend_ff, s1_pend_in;

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff  <= col_ff;
         s1_row_ff  <= row_ff;
         s1_cur_ff  <= (req.grey_pixel >= thresh_ff);
         s1_left_ff <= (col_ff == AW'(1));
         s1_top_ff  <= (row_ff == RW'(1));
         s1_wrap_ff <= col_end && row_end;
      end
   end

   // window shifts in the new column once the line store answers
   bhd_pkg::win_type win_ff, win_in, win_next;

   assign win_next = {s1_cur_ff, ls_q.newer, ls_q.older, win_ff[8:3]};

   // pick the lowest pending slot
   logic [1:0] sel;
   logic [3:0] pend_left;
   logic       last_beat;

   always_comb begin
      priority if (s1_pend_ff[0]) sel = bhd_pkg::SLOT_CUR_ROW;
      else if (s1_pend_ff[1])     sel = bhd_pkg::SLOT_LAST_ROW;
      else if (s1_pend_ff[2])     sel = bhd_pkg::SLOT_EDGE_COL;
      else                        sel = bhd_pkg::SLOT_FRAME_CORNER;
   end

   assign pend_left = s1_pend_ff & ~(4'b0001 << sel);
   assign last_beat = (pend_left == '0);

   // window coordinates for the selected slot
   logic [1:0] kl, kc, kr, st, sm, sb;
   logic       edge_slot, low_slot;
   logic [1:0] eval;
   logic       hit, centre;

   assign edge_slot = sel[1];   // right edge: column w mirrors to w-2
   assign low_slot  = sel[0];   // bottom row: row h mirrors to h-2

   always_comb begin
      kl = edge_slot ? 2'd1 : (s1_left_ff ? 2'd2 : 2'd0);
      kc = edge_slot ? 2'd2 : 2'd1;
      kr = edge_slot ? 2'd1 : 2'd2;
      st = low_slot  ? 2'd1 : (s1_top_ff ? 2'd2 : 2'd0);
      sm = low_slot  ? 2'd2 : 2'd1;
      sb = low_slot  ? 2'd1 : 2'd2;
   end

   assign eval   = bhd_pkg::hole_eval(win_next, kl, kc, kr, st, sm, sb);
   assign hit    = eval[1];
   assign centre = eval[0];

   // ---------------- defect count ----------------
   logic [CW-1:0] defect_ff, defect_in, defect_inc;

   assign defect_inc = (hit && defect_ff != bhd_pkg::COUNT_MAX) ?
                       defect_ff + CW'(1) : defect_ff;

   // ---------------- output register ----------------
   logic     rsp_valid_ff, rsp_valid_in;
   beat_type rsp_beat_ff, beat;
   logic     out_free;
   logic     emit;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign emit     = s1_valid_ff && (s1_pend_ff != '0) && out_free;
   assign retire   = s1_valid_ff && ((s1_pend_ff == '0) || (emit && last_beat));
   assign req.ready = !s1_valid_ff || retire;

   always_comb begin
      beat.out_pixel    = (centre || hit) ? bhd_pkg::PIX_ON : bhd_pkg::PIX_OFF;
      beat.is_defect    = hit;
      beat.pixel_col    = {{(SW-AW){1'b0}}, s1_col_ff} + {{(SW-1){1'b0}}, edge_slot};
      beat.pixel_row    = {{(SW-RW){1'b0}}, s1_row_ff} + {{(SW-1){1'b0}}, low_slot};
      beat.defect_total = defect_inc;
      beat.run_last     = last_beat;
      beat.frame_done   = (sel == bhd_pkg::SLOT_FRAME_CORNER);
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_beat_ff <= beat;
      end
   end

   // ---------------- next state ----------------
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_pend_in  = s1_pend_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_pend_in  = pend_new;
      end else if (retire) begin
         s1_valid_in = 1'b0;
         s1_pend_in  = '0;
      end else if (emit) begin
         s1_pend_in  = pend_left;
      end

      win_in = win_ff;
      if (size_wr)     win_in = '0;
      else if (retire) win_in = win_next;

      defect_in = defect_ff;
      if (size_wr)                   defect_in = '0;
      else if (retire && s1_wrap_ff) defect_in = '0;  // new frame
      else if (emit)                 defect_in = defect_inc;

      rsp_valid_in = rsp_valid_ff;
      if (emit)           rsp_valid_in = 1'b1;
      else if (rsp.ready) rsp_valid_in = 1'b0;
   end

   // row shift in the line store as the pixel leaves
   assign ls_wr.en         = retire;
   assign ls_wr.addr       = s1_col_ff;
   assign ls_wr.data.older = ls_q.newer;
   assign ls_wr.data.newer = s1_cur_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= bhd_pkg::WIDTH_RST;
         height_ff    <= bhd_pkg::HEIGHT_RST;
         thresh_ff    <= bhd_pkg::THRESH_RST;
         col_ff       <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         s1_pend_ff   <= '0;
         win_ff       <= '0;
         defect_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         thresh_ff    <= thresh_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         s1_valid_ff  <= s1_valid_in;
         s1_pend_ff   <= s1_pend_in;
         win_ff       <= win_in;
         defect_ff    <= defect_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.out_pixel    = rsp_beat_ff.out_pixel;
   assign rsp.is_defect    = rsp_beat_ff.is_defect;
   assign rsp.pixel_col    = rsp_beat_ff.pixel_col;
   assign rsp.pixel_row    = rsp_beat_ff.pixel_row;
   assign rsp.defect_total = rsp_beat_ff.defect_total;
   assign rsp.run_last     = rsp_beat_ff.run_last;
   assign rsp.frame_done   = rsp_beat_ff.frame_done;

endmodule

>>> rtl/bhd_line_store.sv
`timescale 1ns / 1ps

// two binarized rows per column, one entry per column, registered read
module bhd_line_store (
   input  logic                   clock,
   input  bhd_pkg::ls_rd_type     rd,
   output bhd_pkg::ls_entry_type  rd_data,
   input  bhd_pkg::ls_wr_type     wr
);

   bhd_pkg::ls_entry_type mem [bhd_pkg::MAX_WIDTH];
   bhd_pkg::ls_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sim/binary_hole_defect_detector_tb.sv
`timescale 1ns / 1ps

// Pinhole detector bench.
// Grey pixels go in on req, one beat per pixel; every rsp beat is checked field
// by field against the oldest output pixel still due from the predictor below.
module binary_hole_defect_detector_tb;

   localparam int PW  = bhd_pkg::PIX_W;
   localparam int SW  = bhd_pkg::SIZE_W;
   localparam int CW  = bhd_pkg::CSR_W;
   localparam int KW  = bhd_pkg::COUNT_W;
   localparam int XW  = bhd_pkg::IDX_W;

   localparam logic [XW-1:0] CSR_UNUSED = 2'd3;   // no register here, block ignores it
   localparam int WIDE_ITEMS    = 8;
   localparam int TALL_ITEMS    = 32;
   localparam int RANDOM_ITEMS  = 200;
   localparam int HOLD_CYCLES   = 400;                // long rsp back-pressure
   localparam int SETTLE_CYCLES = 32;                 // pipeline flush after last beat
   localparam int LIMIT_CYCLES  = 100000;

   // one output pixel as the block should report it
   typedef struct packed {
      logic [PW-1:0]      out_pixel;
      logic               is_defect;
      logic [SW-1:0]      pixel_col;
      logic [SW-1:0]      pixel_row;
      logic [KW-1:0]      defect_total;
      logic               run_last;
      logic               frame_done;
   } out_beat_type;

   logic clock = 1'b0;
   logic reset;
   logic          csr_wr_en;
   logic [XW-1:0] csr_index;
   logic [CW-1:0] csr_wdata;

   bhd_req_if req_ch ();
   bhd_rsp_if rsp_ch ();

   binary_hole_defect_detector uut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------------------
   // Predictor state: registers, two line stores, 3x3 window, raster position
   // ---------------------------------------------------------------------------
   logic [SW-1:0]      width_reg;
   logic [SW-1:0]      height_reg;
   logic [PW-1:0]      thresh_reg;
   logic               older_line [bhd_pkg::MAX_WIDTH];   // row r-2
   logic               newer_line [bhd_pkg::MAX_WIDTH];   // row r-1
   bhd_pkg::win_type   hole_win;                 // bit k*3+s: column k, row slot s
   int                 at_col;
   int                 at_row;
   logic [KW-1:0]      defects_seen;

   out_beat_type       due_pixels [$];           // output pixels not yet seen on rsp
   logic [PW-1:0]      grey_feed [$];            // pixels waiting for the driver

   int   mismatches = 0;
   int   cycle_count = 0;
   int   burst_left = 0;
   int   gap_left = 0;
   int   hold_left = 0;
   int   holds_asked = 0;
   int   holds_done = 0;
   logic [15:0] stall_pattern;
   logic rx_eager = 1'b0;
   logic noise_mode = 1'b0;

   // sizes outside 2..max are clamped
   function automatic int clamp_size(logic [SW-1:0] v, int maxv);
      if (v < 2) return 2;
      if (v > maxv) return maxv;
      return int'(v);
   endfunction

   function automatic logic win_at(int k, int s);
      return hole_win[k * 3 + s];
   endfunction

   // Evaluate one window arrangement. kl/kc/kr pick the window columns and
   // st/sm/sb the row slots, which is how the mirror padding is expressed.
   function automatic out_beat_type match_hole(int kl, int kc, int kr, int st, int sm,
                                               int sb, int col, int row, logic corner);
      out_beat_type res;
      logic ring;
      logic centre;
      logic hit;
      ring = win_at(kl, st) & win_at(kc, st) & win_at(kr, st)
           & win_at(kl, sm) & win_at(kr, sm)
           & win_at(kl, sb) & win_at(kc, sb) & win_at(kr, sb);
      centre = win_at(kc, sm);
      hit = ring & ~centre;
      if (hit && defects_seen != bhd_pkg::COUNT_MAX) defects_seen++;
      res.out_pixel    = (centre | hit) ? bhd_pkg::PIX_ON : bhd_pkg::PIX_OFF;
      res.is_defect    = hit;
      res.pixel_col    = SW'(col);
      res.pixel_row    = SW'(row);
      res.defect_total = defects_seen;
      res.run_last     = 1'b0;
      res.frame_done   = corner;
      return res;
   endfunction

   // Binarize one accepted pixel, shift the window and queue the output pixels
   // it releases. Output trails input by a row and a pixel; the last input row
   // also releases the last output row, interleaved per column.
   task automatic binarize_and_match(input logic [PW-1:0] grey);
      int w;
      int h;
      int c;
      int r;
      int n;
      int i;
      int top;
      int left;
      logic cur;
      logic bottom_row;
      out_beat_type found [4];
      w = clamp_size(width_reg, bhd_pkg::MAX_WIDTH);
      h = clamp_size(height_reg, bhd_pkg::MAX_HEIGHT);
      c = at_col;
      r = at_row;
      n = 0;
      if (c >= w) c = w - 1;
      if (r >= h) r = h - 1;
      cur = (grey >= thresh_reg);
      hole_win = {cur, newer_line[c], older_line[c], hole_win[8:3]};
      if (r >= 1) begin
         top = (r == 1) ? 2 : 0;          // row -1 mirrors row 1
         bottom_row = (r == h - 1);
         if (c >= 1) begin
            left = (c == 1) ? 2 : 0;      // column -1 mirrors column 1
            found[n] = match_hole(left, 1, 2, top, 1, 2, c, r, 1'b0);
            n++;
            if (bottom_row) begin
               found[n] = match_hole(left, 1, 2, 1, 2, 1, c, r + 1, 1'b0);
               n++;
            end
         end
         if (c == w - 1) begin            // right edge: column W mirrors W-2
            found[n] = match_hole(1, 2, 1, top, 1, 2, c + 1, r, 1'b0);
            n++;
            if (bottom_row) begin
               found[n] = match_hole(1, 2, 1, 1, 2, 1, c + 1, r + 1, 1'b1);
               n++;
            end
         end
         for (i = 0; i < n; i++) begin
            found[i].run_last = (i == n - 1);
            due_pixels = {due_pixels, found[i]};
         end
      end
      older_line[c] = newer_line[c];
      newer_line[c] = cur;
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) begin
            r = 0;
            defects_seen = '0;
         end
      end
      at_col = c;
      at_row = r;
   endtask

   // ---------------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------------
   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   task automatic check_out_beat();
      out_beat_type want;
      if (due_pixels.size() == 0) begin
         $error("output beat with nothing due: row %0d col %0d",
                rsp_ch.pixel_row, rsp_ch.pixel_col);
         mismatches++;
      end else begin
         want = due_pixels.pop_front();
         check_field("out_pixel", 32'(want.out_pixel), 32'(rsp_ch.out_pixel));
         check_field("is_defect", 32'(want.is_defect), 32'(rsp_ch.is_defect));
         check_field("pixel_col", 32'(want.pixel_col), 32'(rsp_ch.pixel_col));
         check_field("pixel_row", 32'(want.pixel_row), 32'(rsp_ch.pixel_row));
         check_field("defect_total", 32'(want.defect_total), 32'(rsp_ch.defect_total));
         check_field("run_last", 32'(want.run_last), 32'(rsp_ch.run_last));
         check_field("frame_done", 32'(want.frame_done), 32'(rsp_ch.frame_done));
      end
   endtask

   // ---------------------------------------------------------------------------
   // Driver: bursts of random length, random gaps; predicts on each accepted beat
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid      <= 1'b0;
         req_ch.grey_pixel <= '0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            binarize_and_match(req_ch.grey_pixel);
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_ch.valid <= 1'b0;
            end else if (grey_feed.size() > 0) begin
               req_ch.valid      <= 1'b1;
               req_ch.grey_pixel <= grey_feed.pop_front();
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = int'($urandom_range(1, 24));
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0
                                                           : int'($urandom_range(1, 6));
               end
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Monitor: rotating stall pattern, long hold-offs on request, checks beats
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_pattern = 16'($urandom) | 16'h1111;   // a ready bit in every nibble
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) check_out_beat();
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (holds_asked != holds_done) begin
            holds_done++;
            hold_left = HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
         end else begin
            stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
            rsp_ch.ready <= stall_pattern[0] | rx_eager;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("binary_hole_defect_detector_tb: errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------

   // register write; the predictor takes it once the block has seen it
   task automatic write_reg(input logic [XW-1:0] idx, input logic [CW-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         bhd_pkg::CSR_FRAME_WIDTH, bhd_pkg::CSR_FRAME_HEIGHT: begin
            // size change restarts the frame
            if (idx == bhd_pkg::CSR_FRAME_WIDTH) width_reg = data;
            else height_reg = data;
            hole_win     = '0;
            at_col       = 0;
            at_row       = 0;
            defects_seen = '0;
         end
         bhd_pkg::CSR_THRESHOLD: thresh_reg = data[PW-1:0];
         default: ;
      endcase
   endtask

   // mostly ones so that rings close around the odd zero; noise phases are flat
   function automatic logic [PW-1:0] random_grey();
      if (noise_mode) return PW'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < 85 || thresh_reg == 0)
         return PW'($urandom_range(thresh_reg, 255));
      return PW'($urandom_range(0, thresh_reg - 1));
   endfunction

   function automatic logic [CW-1:0] pick_threshold();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return CW'(255);
         2: return CW'(11'h700 | $urandom_range(0, 255));   // upper bits dropped
         default: return CW'($urandom_range(1, 254));
      endcase
   endfunction

   // wait until every pixel is in and every output checked, then let it settle
   task automatic drain();
      @(negedge clock);
      while (grey_feed.size() != 0 || req_ch.valid || due_pixels.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic fill_frame(input int count);
      int i;
      @(negedge clock);
      rx_eager   = ($urandom_range(0, 3) == 0);
      noise_mode = ($urandom_range(0, 7) == 0);
      for (i = 0; i < count; i++) grey_feed = {grey_feed, random_grey()};
      drain();
   endtask

   // ---------------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------------
   initial begin
      int w;
      int h;
      int n;
      int i;
      int random_sent;
      int phase_no;

      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;

      width_reg    = bhd_pkg::WIDTH_RST;
      height_reg   = bhd_pkg::HEIGHT_RST;
      thresh_reg   = bhd_pkg::THRESH_RST;
      hole_win     = '0;
      at_col       = 0;
      at_row       = 0;
      defects_seen = '0;
      for (i = 0; i < bhd_pkg::MAX_WIDTH; i++) begin
         older_line[i] = 1'b0;
         newer_line[i] = 1'b0;
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // 4x4, threshold 128: holes in the top-left corner, the interior and the
      // bottom-left corner; grey levels sit on both sides of the threshold
      write_reg(bhd_pkg::CSR_FRAME_WIDTH, 11'd4);
      write_reg(bhd_pkg::CSR_FRAME_HEIGHT, 11'd4);
      write_reg(bhd_pkg::CSR_THRESHOLD, 11'd128);
      write_reg(CSR_UNUSED, 11'h7FF);
      @(negedge clock);
      grey_feed = '{8'd0,   8'd128, 8'd255, 8'd200,
                    8'd129, 8'd255, 8'd128, 8'd170,
                    8'd255, 8'd128, 8'd127, 8'd255,
                    8'd64,  8'd255, 8'd128, 8'd255};
      drain();

      // undersized frame, clamps to 2x2; mirrored window makes (1,1) a hole
      write_reg(bhd_pkg::CSR_FRAME_WIDTH, 11'd1);
      write_reg(bhd_pkg::CSR_FRAME_HEIGHT, 11'd0);
      @(negedge clock);
      grey_feed = '{8'd100, 8'd200, 8'd255, 8'd128};
      drain();

      // oversize width clamps; a partial first row only
      write_reg(bhd_pkg::CSR_FRAME_WIDTH, 11'h7FF);
      write_reg(bhd_pkg::CSR_FRAME_HEIGHT, 11'd2);
      write_reg(bhd_pkg::CSR_THRESHOLD, 11'd128);
      fill_frame(WIDE_ITEMS);

      // oversize height clamps, two columns; rsp held off while pixels keep coming
      write_reg(bhd_pkg::CSR_FRAME_WIDTH, 11'd2);
      write_reg(bhd_pkg::CSR_FRAME_HEIGHT, 11'h7FF);
      holds_asked++;
      fill_frame(TALL_ITEMS);

      // small random frames, threshold moves, partial frames
      random_sent = 0;
      phase_no = 0;
      while (random_sent < RANDOM_ITEMS) begin
         if (phase_no > 0 && $urandom_range(0, 3) == 0) begin
            // threshold change keeps the raster position
            write_reg(bhd_pkg::CSR_THRESHOLD, pick_threshold());
            n = int'($urandom_range(3, 20));
         end else begin
            w = int'($urandom_range(2, 9));
            h = int'($urandom_range(2, 6));
            write_reg(bhd_pkg::CSR_FRAME_WIDTH, SW'(w));
            write_reg(bhd_pkg::CSR_FRAME_HEIGHT, SW'(h));
            if ($urandom_range(0, 1) == 0) write_reg(bhd_pkg::CSR_THRESHOLD, pick_threshold());
            if ($urandom_range(0, 5) == 0)
               write_reg(CSR_UNUSED, CW'($urandom_range(0, 2047)));
            // back-to-back frames check the defect count restart
            n = ($urandom_range(0, 4) == 0) ? int'($urandom_range(1, w * h))
                                            : w * h * int'($urandom_range(1, 2));
         end
         if (n > RANDOM_ITEMS - random_sent) n = RANDOM_ITEMS - random_sent;
         if (phase_no == 3) holds_asked++;
         fill_frame(n);
         random_sent += n;
         phase_no++;
      end

      drain();
      if (mismatches == 0) begin
         $display("binary_hole_defect_detector_tb: clean");
      end else begin
         $display("binary_hole_defect_detector_tb: errors");
      end
      $finish;
   end

endmodule

>>> binary_hole_defect_detector.f
rtl/bhd_pkg.sv
rtl/bhd_req_if.sv
rtl/bhd_rsp_if.sv
rtl/bhd_line_store.sv
rtl/binary_hole_defect_detector.sv
sim/binary_hole_defect_detector_tb.sv
